>>> rtl/core/utf8md_pkg.sv
// Shared types and constants for the UTF-8 multibyte decoder pipeline.
// No dependencies; imported by every stage module and the top level.
`default_nettype none

package utf8md_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 3;
  localparam int unsigned CP_W   = 21;

  localparam logic [CP_W-1:0]  BAD_CHAR_RESET = 21'h00FFFD;

  localparam logic [LEN_W-1:0] LEN_ONE   = 3'd1;
  localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
  localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
  localparam logic [LEN_W-1:0] LEN_FOUR  = 3'd4;

  // Lead byte prefixes for the multibyte forms
  localparam logic [2:0] LEAD2_PREFIX = 3'b110;
  localparam logic [3:0] LEAD3_PREFIX = 4'b1110;
  localparam logic [4:0] LEAD4_PREFIX = 5'b11110;
  localparam logic [1:0] CONT_PREFIX  = 2'b10;

  typedef enum logic [1:0] {
    FORM_NONE,
    FORM_TWO,
    FORM_THREE,
    FORM_FOUR
  } form_e;

  // Stage 1 -> stage 2: classified sequence with raw bytes
  typedef struct packed {
    logic              valid;
    form_e             form;
    logic [BYTE_W-1:0] b0;
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] b2;
    logic [BYTE_W-1:0] b3;
  } cap_t;

  // Stage 2 -> stage 3: assembled code point and overlong flag
  typedef struct packed {
    logic            valid;
    form_e           form;
    logic            overlong;
    logic [CP_W-1:0] cp;
  } asm_t;

endpackage

`default_nettype wire

>>> rtl/core/utf8md_capture.sv
// Stage 1: register the bytes and classify the sequence form.
// Depends on utf8md_pkg.
`default_nettype none

module utf8md_capture (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic [utf8md_pkg::BYTE_W-1:0]  lead_byte_i,
  input  logic [utf8md_pkg::BYTE_W-1:0]  second_byte_i,
  input  logic [utf8md_pkg::BYTE_W-1:0]  third_byte_i,
  input  logic [utf8md_pkg::BYTE_W-1:0]  fourth_byte_i,
  input  logic [utf8md_pkg::LEN_W-1:0]   avail_len_i,
  output utf8md_pkg::cap_t               cap_o
);
  import utf8md_pkg::*;

  logic  c1_ok, c2_ok, c3_ok;
  logic  has2, has3, has4;
  form_e form_d;
  cap_t  cap_q;

  // Lengths above four compare the same as four here, so no clamp is needed
  assign has2  = (avail_len_i >= LEN_TWO);
  assign has3  = (avail_len_i >= LEN_THREE);
  assign has4  = (avail_len_i >= LEN_FOUR);
  assign c1_ok = (second_byte_i[7:6] == CONT_PREFIX);
  assign c2_ok = (third_byte_i[7:6] == CONT_PREFIX);
  assign c3_ok = (fourth_byte_i[7:6] == CONT_PREFIX);

  always_comb begin
    form_d = FORM_NONE;
    if (has2 && c1_ok && lead_byte_i[7:5] == LEAD2_PREFIX) begin
      form_d = FORM_TWO;
    end else if (has3 && c1_ok && c2_ok && lead_byte_i[7:4] == LEAD3_PREFIX) begin
      form_d = FORM_THREE;
    end else if (has4 && c1_ok && c2_ok && c3_ok &&
                 lead_byte_i[7:3] == LEAD4_PREFIX) begin
      form_d = FORM_FOUR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= '0;
    end else begin
      cap_q.valid <= in_valid_i;
      cap_q.form  <= form_d;
      cap_q.b0    <= lead_byte_i;
      cap_q.b1    <= second_byte_i;
      cap_q.b2    <= third_byte_i;
      cap_q.b3    <= fourth_byte_i;
    end
  end

  assign cap_o = cap_q;

endmodule

`default_nettype wire

>>> rtl/core/utf8md_assemble.sv
// Stage 2: assemble the code point bits and detect overlong encodings.
// Depends on utf8md_pkg.
`default_nettype none

module utf8md_assemble (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  utf8md_pkg::cap_t cap_i,
  output utf8md_pkg::asm_t asm_o
);
  import utf8md_pkg::*;

  logic [CP_W-1:0] cp_d;
  logic            overlong_d;
  asm_t            asm_q;

  always_comb begin
    cp_d       = '0;
    overlong_d = 1'b0;
    unique case (cap_i.form)
      FORM_TWO: begin
        cp_d       = {10'd0, cap_i.b0[4:0], cap_i.b1[5:0]};
        overlong_d = (cap_i.b0[4:1] == 4'd0);
      end
      FORM_THREE: begin
        cp_d       = {5'd0, cap_i.b0[3:0], cap_i.b1[5:0], cap_i.b2[5:0]};
        overlong_d = (cap_i.b0[3:0] == 4'd0) && !cap_i.b1[5];
      end
      FORM_FOUR: begin
        cp_d       = {cap_i.b0[2:0], cap_i.b1[5:0], cap_i.b2[5:0], cap_i.b3[5:0]};
        overlong_d = (cap_i.b0[2:0] == 3'd0) && (cap_i.b1[5:4] == 2'd0);
      end
      default: begin
        cp_d       = '0;
        overlong_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      asm_q <= '0;
    end else begin
      asm_q.valid    <= cap_i.valid;
      asm_q.form     <= cap_i.form;
      asm_q.overlong <= overlong_d;
      asm_q.cp       <= cp_d;
    end
  end

  assign asm_o = asm_q;

endmodule

`default_nettype wire

>>> rtl/core/utf8md_emit.sv
// Stage 3: pick the decoded value or the bad character into the result register.
// Depends on utf8md_pkg.
`default_nettype none

module utf8md_emit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  utf8md_pkg::asm_t            asm_i,
  input  logic [utf8md_pkg::CP_W-1:0] bad_char_i,
  output logic                        done_o,
  output logic [utf8md_pkg::CP_W-1:0] code_point_o,
  output logic [utf8md_pkg::LEN_W-1:0] consumed_o,
  output logic                        malformed_o
);
  import utf8md_pkg::*;

  logic             bad;
  logic [LEN_W-1:0] len_d;
  logic             done_q;
  logic [CP_W-1:0]  code_point_q;
  logic [LEN_W-1:0] consumed_q;
  logic             malformed_q;

  assign bad = (asm_i.form == FORM_NONE) || asm_i.overlong;

  always_comb begin
    unique case (asm_i.form)
      FORM_TWO:   len_d = LEN_TWO;
      FORM_THREE: len_d = LEN_THREE;
      FORM_FOUR:  len_d = LEN_FOUR;
      default:    len_d = LEN_ONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= asm_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    code_point_q <= bad ? bad_char_i : asm_i.cp;
    consumed_q   <= bad ? LEN_ONE : len_d;
    malformed_q  <= bad;
  end

  assign done_o       = done_q;
  assign code_point_o = code_point_q;
  assign consumed_o   = consumed_q;
  assign malformed_o  = malformed_q;

endmodule

`default_nettype wire

>>> rtl/core/utf8_multibyte_decode.sv
// UTF-8 multibyte decoder: three register stages, classify, assemble, select.
// A taken item reaches done_o via the capture, assemble and emit registers.
// Throughput: one item per cycle; busy stays low, the pipeline never stalls.
// Reset clears the stage valid bits and loads the bad character with U+FFFD.
// Depends on utf8md_pkg, utf8md_capture, utf8md_assemble, utf8md_emit.
`default_nettype none

module utf8_multibyte_decode (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [utf8md_pkg::BYTE_W-1:0] lead_byte_i,
  input  logic [utf8md_pkg::BYTE_W-1:0] second_byte_i,
  input  logic [utf8md_pkg::BYTE_W-1:0] third_byte_i,
  input  logic [utf8md_pkg::BYTE_W-1:0] fourth_byte_i,
  input  logic [utf8md_pkg::LEN_W-1:0]  avail_len_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [utf8md_pkg::CP_W-1:0]   cfg_data_i,
  output logic                          done_o,
  output logic [utf8md_pkg::CP_W-1:0]   code_point_o,
  output logic [utf8md_pkg::LEN_W-1:0]  consumed_o,
  output logic                          malformed_o
);
  import utf8md_pkg::*;

  logic [CP_W-1:0] bad_char_q;
  logic            accept;
  cap_t            cap;
  asm_t            asm_s;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bad_char_q <= BAD_CHAR_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      bad_char_q <= cfg_data_i;
    end
  end

  utf8md_capture u_capture (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (accept),
    .lead_byte_i   (lead_byte_i),
    .second_byte_i (second_byte_i),
    .third_byte_i  (third_byte_i),
    .fourth_byte_i (fourth_byte_i),
    .avail_len_i   (avail_len_i),
    .cap_o         (cap)
  );

  utf8md_assemble u_assemble (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cap_i  (cap),
    .asm_o  (asm_s)
  );

  utf8md_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .asm_i        (asm_s),
    .bad_char_i   (bad_char_q),
    .done_o       (done_o),
    .code_point_o (code_point_o),
    .consumed_o   (consumed_o),
    .malformed_o  (malformed_o)
  );

endmodule

`default_nettype wire

>>> rtl/core/utf8md_checker.sv
// Port-level checks for the UTF-8 multibyte decoder, bound to the top level.
// Depends on utf8md_pkg and utf8_multibyte_decode.
`default_nettype none

module utf8md_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic                          done_o,
  input logic [utf8md_pkg::CP_W-1:0]   code_point_o,
  input logic [utf8md_pkg::LEN_W-1:0]  consumed_o,
  input logic                          malformed_o
);
  import utf8md_pkg::*;

  // Every taken item yields a result on done_o
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##3 done_o)
    else $error("result missing three cycles after an item was taken");

  // No result without a matching taken item
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 3))
    else $error("result strobe without a matching item");

  a_bad_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && malformed_o) |-> (consumed_o == LEN_ONE))
    else $error("malformed result must consume one byte");

  a_good_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !malformed_o) |->
      (consumed_o == LEN_TWO || consumed_o == LEN_THREE || consumed_o == LEN_FOUR))
    else $error("well-formed result with bad length");

  // Two-byte results are never overlong and fit in eleven bits
  a_two_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !malformed_o && consumed_o == LEN_TWO) |->
      (code_point_o >= 21'h80 && code_point_o <= 21'h7FF))
    else $error("two-byte code point out of range");

endmodule

bind utf8_multibyte_decode utf8md_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .code_point_o (code_point_o),
  .consumed_o   (consumed_o),
  .malformed_o  (malformed_o)
);

`default_nettype wire
